// ===== hw/rtl/gaussian_simpson_integrator_assert.svh =====
// assertion helpers used by the integrator top-level rtl
`ifndef GAUSSIAN_SIMPSON_INTEGRATOR_ASSERT_SVH
`define GAUSSIAN_SIMPSON_INTEGRATOR_ASSERT_SVH

// check that holds at every clock out of reset
`define GSI_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define GSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gsi_pkg.sv =====
// ----------------------------------------------------------------------------
// gsi_pkg
// Types and constants of the Gaussian Simpson integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gsi_pkg;

  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned NUM_W       = 46;
  localparam int unsigned AN_W        = 45;
  localparam int unsigned DEN_W       = 42;
  localparam int unsigned ZQ_W        = 20;
  localparam int unsigned XB_W        = 20;
  localparam int unsigned S_W         = 31;
  localparam int unsigned TERM_W      = 32;
  localparam int unsigned ACC_W       = 34;
  localparam int unsigned TERMS       = 16;
  localparam int unsigned SQUARINGS   = 7;
  localparam int unsigned Q31_SHIFT   = 31;
  localparam int unsigned RECIP_W     = 37;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned SUM_W       = 44;
  localparam int unsigned AMP_W       = 43;
  localparam int unsigned MUL_W       = 48;
  localparam int unsigned MUL_P_W     = 96;
  localparam int unsigned DIV_W       = 80;
  localparam int unsigned DIVR_W      = 44;

  localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;

  // floor(2^36 / k) for k = 1..16
  localparam logic [RECIP_W-1:0] RECIP [TERMS] = '{
    RECIP_W'(RECIP_ONE / 64'd1),  RECIP_W'(RECIP_ONE / 64'd2),
    RECIP_W'(RECIP_ONE / 64'd3),  RECIP_W'(RECIP_ONE / 64'd4),
    RECIP_W'(RECIP_ONE / 64'd5),  RECIP_W'(RECIP_ONE / 64'd6),
    RECIP_W'(RECIP_ONE / 64'd7),  RECIP_W'(RECIP_ONE / 64'd8),
    RECIP_W'(RECIP_ONE / 64'd9),  RECIP_W'(RECIP_ONE / 64'd10),
    RECIP_W'(RECIP_ONE / 64'd11), RECIP_W'(RECIP_ONE / 64'd12),
    RECIP_W'(RECIP_ONE / 64'd13), RECIP_W'(RECIP_ONE / 64'd14),
    RECIP_W'(RECIP_ONE / 64'd15), RECIP_W'(RECIP_ONE / 64'd16)
  };

  localparam logic [TERM_W-1:0] ONE_Q31         = 32'h8000_0000;
  localparam logic [63:0]       HALF_Q31        = 64'd1 << 30;
  localparam logic [31:0]       INV_SQRT2PI_Q32 = 32'd1713444047;
  localparam logic [31:0]       POS_LIMIT       = 32'h7fff_ffff;
  localparam logic [31:0]       NEG_LIMIT       = 32'h8000_0000;

  typedef enum logic [1:0] {
    WT_ONE,
    WT_TWO,
    WT_FOUR
  } weight_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_COUNT,
    ST_BAD_DEV,
    ST_SAT
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_FEED,
    S_DRAIN,
    S_MUL_AMP,
    S_MUL_SCALE,
    S_DIVIDE,
    S_PACK,
    S_FINISH
  } gsi_state_e;

  typedef struct packed {
    logic            valid;
    logic            tail;
    weight_e         wt;
    logic [AN_W-1:0] an;
  } bell_in_t;

  typedef struct packed {
    logic              valid;
    weight_e           wt;
    logic [TERM_W-1:0] e;
  } bell_out_t;

  typedef struct packed {
    logic    tail;
    weight_e wt;
  } bell_tag_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gsi_bell_pipe.sv =====
// ----------------------------------------------------------------------------
// gsi_bell_pipe
// Fully pipelined exp(-z^2/2) evaluator: bit-per-stage divider, square,
// sixteen Taylor terms of exp(-z^2/256) and seven squarings, Q31 result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsi_bell_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [gsi_pkg::DEN_W-1:0]     den_i,
  input  gsi_pkg::bell_in_t             item_i,
  output gsi_pkg::bell_out_t            item_o,
  output logic                          busy_o
);

  localparam int unsigned DW   = gsi_pkg::DEN_W;
  localparam int unsigned XW   = gsi_pkg::XB_W;
  localparam int unsigned ZW   = gsi_pkg::ZQ_W;
  localparam int unsigned SW   = gsi_pkg::S_W;
  localparam int unsigned TW   = gsi_pkg::TERM_W;
  localparam int unsigned AW   = gsi_pkg::ACC_W;
  localparam int unsigned RW   = gsi_pkg::RECIP_W;
  localparam int unsigned NT   = gsi_pkg::TERMS;
  localparam int unsigned NSQ  = gsi_pkg::SQUARINGS;
  localparam int unsigned PAW  = TW + SW;
  localparam int unsigned PBW  = TW + RW;
  localparam int unsigned FRAC = 16;

  // divider stages
  logic [ZW:0]          dv_q;
  gsi_pkg::bell_tag_t   dtag_q [ZW+1];
  logic [DW-1:0]        rem_q  [ZW+1];
  logic [XW-1:0]        xb_q   [ZW+1];
  logic [ZW-1:0]        zq_q   [ZW+1];
  logic [DW:0]          trial  [ZW];
  logic [ZW-1:0]        ge;

  // taylor stages: tc index 0 is the squared-z stage
  logic [NT-1:0]        tav_q, tbv_q;
  logic [NT:0]          tcv_q;
  gsi_pkg::bell_tag_t   tatag_q [NT];
  gsi_pkg::bell_tag_t   tbtag_q [NT];
  gsi_pkg::bell_tag_t   tctag_q [NT+1];
  logic [SW-1:0]        ta_s_q [NT];
  logic [SW-1:0]        tb_s_q [NT];
  logic [SW-1:0]        tc_s_q [NT+1];
  logic signed [AW-1:0] ta_acc_q [NT];
  logic signed [AW-1:0] tb_acc_q [NT];
  logic signed [AW-1:0] tc_acc_q [NT+1];
  logic [TW-1:0]        ta_p_q  [NT];
  logic [TW-1:0]        tb_p_q  [NT];
  logic [TW-1:0]        tb_q0_q [NT];
  logic [TW-1:0]        tc_term_q [NT+1];
  logic [PAW-1:0]       pa [NT];
  logic [PBW-1:0]       pb [NT];
  logic [TW-1:0]        kv [NT];
  logic [TW-1:0]        back [NT];
  logic [TW-1:0]        resid [NT];
  logic [TW-1:0]        qq [NT];

  // clamp and squaring stages
  logic [NSQ:0]         sqv_q;
  gsi_pkg::bell_tag_t   sqtag_q [NSQ+1];
  logic [TW-1:0]        sq_g_q [NSQ+1];
  logic [63:0]          gg [NSQ];

  logic [gsi_pkg::AN_W-1:0] an_use;
  logic [2*ZW-1:0]          zsq;

  assign an_use = item_i.tail ? '0 : item_i.an;
  assign zsq    = (2*ZW)'(zq_q[ZW]) * (2*ZW)'(zq_q[ZW]);

  always_comb begin
    for (int j = 0; j < ZW; j++) begin
      trial[j] = {rem_q[j], xb_q[j][XW-1]};
      ge[j]    = trial[j] >= {1'b0, den_i};
    end
    for (int m = 0; m < NT; m++) begin
      pa[m]    = PAW'(tc_term_q[m]) * PAW'(tc_s_q[m]);
      pb[m]    = PBW'(ta_p_q[m]) * PBW'(gsi_pkg::RECIP[m]);
      kv[m]    = TW'(m + 1);
      back[m]  = tb_q0_q[m] * kv[m];
      resid[m] = tb_p_q[m] - back[m];
      qq[m]    = (resid[m] >= kv[m]) ? tb_q0_q[m] + 1'b1 : tb_q0_q[m];
    end
    for (int j = 0; j < NSQ; j++) begin
      gg[j] = 64'(sq_g_q[j]) * 64'(sq_g_q[j]) + gsi_pkg::HALF_Q31;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q  <= '0;
      tav_q <= '0;
      tbv_q <= '0;
      tcv_q <= '0;
      sqv_q <= '0;
    end else begin
      dv_q  <= {dv_q[ZW-1:0], item_i.valid};
      tav_q <= tcv_q[NT-1:0];
      tbv_q <= tav_q;
      tcv_q <= {tbv_q, dv_q[ZW]};
      sqv_q <= {sqv_q[NSQ-1:0], tcv_q[NT]};
    end
  end

  always_ff @(posedge clk_i) begin
    // dividend is |num| << 16, quotient known to fit in 20 bits
    dtag_q[0] <= '{tail: item_i.tail, wt: item_i.wt};
    rem_q[0]  <= DW'(an_use >> 4);
    xb_q[0]   <= {an_use[3:0], FRAC'(0)};
    zq_q[0]   <= '0;
    for (int j = 0; j < ZW; j++) begin
      dtag_q[j+1] <= dtag_q[j];
      rem_q[j+1]  <= ge[j] ? DW'(trial[j] - {1'b0, den_i}) : trial[j][DW-1:0];
      xb_q[j+1]   <= xb_q[j] << 1;
      zq_q[j+1]   <= {zq_q[j][ZW-2:0], ge[j]};
    end

    // s = (zq^2 >> 17) << 8
    tctag_q[0]   <= dtag_q[ZW];
    tc_s_q[0]    <= {zsq[2*ZW-1:17], 8'b0};
    tc_term_q[0] <= gsi_pkg::ONE_Q31;
    tc_acc_q[0]  <= $signed(AW'(gsi_pkg::ONE_Q31));

    for (int m = 0; m < NT; m++) begin
      tatag_q[m]  <= tctag_q[m];
      ta_s_q[m]   <= tc_s_q[m];
      ta_acc_q[m] <= tc_acc_q[m];
      ta_p_q[m]   <= pa[m][PAW-1:gsi_pkg::Q31_SHIFT];

      tbtag_q[m]  <= tatag_q[m];
      tb_s_q[m]   <= ta_s_q[m];
      tb_acc_q[m] <= ta_acc_q[m];
      tb_p_q[m]   <= ta_p_q[m];
      tb_q0_q[m]  <= pb[m][gsi_pkg::RECIP_SHIFT +: TW];

      // reciprocal estimate is at most one low, fixed by one compare
      tctag_q[m+1]   <= tbtag_q[m];
      tc_s_q[m+1]    <= tb_s_q[m];
      tc_term_q[m+1] <= qq[m];
      if (m[0] == 1'b0) begin
        tc_acc_q[m+1] <= tb_acc_q[m] - $signed(AW'(qq[m]));
      end else begin
        tc_acc_q[m+1] <= tb_acc_q[m] + $signed(AW'(qq[m]));
      end
    end

    sqtag_q[0] <= tctag_q[NT];
    if (tc_acc_q[NT][AW-1]) begin
      sq_g_q[0] <= '0;
    end else if (tc_acc_q[NT] > $signed(AW'(gsi_pkg::ONE_Q31))) begin
      sq_g_q[0] <= gsi_pkg::ONE_Q31;
    end else begin
      sq_g_q[0] <= tc_acc_q[NT][TW-1:0];
    end
    for (int j = 0; j < NSQ; j++) begin
      sqtag_q[j+1] <= sqtag_q[j];
      sq_g_q[j+1]  <= gg[j][gsi_pkg::Q31_SHIFT +: TW];
    end
  end

  assign item_o.valid = sqv_q[NSQ];
  assign item_o.wt    = sqtag_q[NSQ].wt;
  assign item_o.e     = sqtag_q[NSQ].tail ? '0 : sq_g_q[NSQ];

  assign busy_o = (|dv_q) | (|tav_q) | (|tbv_q) | (|tcv_q) | (|sqv_q);

endmodule

`default_nettype wire

// ===== hw/rtl/gaussian_simpson_integrator.sv =====
// ----------------------------------------------------------------------------
// gaussian_simpson_integrator
// Composite Simpson integral of a Gaussian density, Q16.16 in and out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one job per transfer: start, end, mean, deviation and the
//   interval count n. m_axis returns one result per job: the saturated
//   integral and a status code.
//   A job with a bad count or a non-positive deviation goes from the setup
//   state straight to the finish state. For a valid job, n + 1 sample points
//   go into the density pipeline one per cycle (78 stages deep), then the
//   1/sqrt(2 pi) scale and the width product run on a 48 x 16 multiplier in
//   three steps each, and the final division by 3 n sigma runs one quotient
//   bit per cycle. One job is in flight at a time; s_axis is ready again as
//   soon as the result is in the output register.
//   Reset clears the controller and all pipeline valid bits; no memory is
//   involved, so the block is ready right after reset.
//   A stalled m_axis holds its result; a finished job then waits until the
//   output register frees up, and no result is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_simpson_integrator #(
  parameter int unsigned MAX_INTERVALS = 1024,
  parameter int unsigned FRAC_BITS     = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // start_point, end_point, mean_value, std_dev, interval_count, 5 zero bits
  input  logic [143:0] s_axis_tdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // integral, status, 6 zero bits
  output logic [39:0]  m_axis_tdata_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i
);

  `include "gaussian_simpson_integrator_assert.svh"

  localparam int unsigned SHR   = 31 - FRAC_BITS;
  localparam int unsigned NW    = gsi_pkg::NUM_W;
  localparam int unsigned DW    = gsi_pkg::DEN_W;
  localparam int unsigned CW    = gsi_pkg::COUNT_W;
  localparam int unsigned SUMW  = gsi_pkg::SUM_W;
  localparam int unsigned AMPW  = gsi_pkg::AMP_W;
  localparam int unsigned MW    = gsi_pkg::MUL_W;
  localparam int unsigned MPW   = gsi_pkg::MUL_P_W;
  localparam int unsigned VW    = gsi_pkg::DIV_W;
  localparam int unsigned RW    = gsi_pkg::DIVR_W;
  localparam int unsigned VCW   = $clog2(VW);
  localparam int unsigned ANW   = gsi_pkg::AN_W;

  gsi_pkg::gsi_state_e state_q, state_d;

  logic signed [31:0]   a_q, b_q, mu_q, sd_q;
  logic [CW-1:0]        n_q;
  logic signed [32:0]   w_q, w_d;
  logic signed [NW-1:0] num_q, num_d;
  logic [DW-1:0]        den_q, den_d;
  logic [RW-1:0]        divisor_q, divisor_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [SUMW-1:0]      sum_q, sum_d;
  logic [MW-1:0]        mul_a_q, mul_a_d, mul_b_q, mul_b_d;
  logic [MPW-1:0]       mul_acc_q, mul_acc_d;
  logic [1:0]           mul_cnt_q, mul_cnt_d;
  logic [VW-1:0]        dvd_q, dvd_d;
  logic [RW-1:0]        rem_q, rem_d;
  logic [VCW-1:0]       div_cnt_q, div_cnt_d;
  logic [31:0]          res_int_q, res_int_d;
  gsi_pkg::status_e     res_st_q, res_st_d;
  logic                 out_valid_q, out_valid_d;
  logic [31:0]          out_int_q, out_int_d;
  gsi_pkg::status_e     out_st_q, out_st_d;

  logic                 in_xfer, out_free, bad_count, bad_dev, neg;
  logic signed [32:0]   d_w;
  logic [32:0]          w_abs;
  logic [ANW-1:0]       an;
  logic [NW-1:0]        num_abs;
  logic [15:0]          chunk;
  logic [63:0]          part;
  logic [MPW-1:0]       mul_sum;
  logic [RW:0]          dtrial;
  logic                 dge;
  logic [31:0]          lim, mag;
  logic                 sat;
  logic [SUMW-1:0]      inc;

  gsi_pkg::bell_in_t    pipe_in;
  gsi_pkg::bell_out_t   pipe_out;
  logic                 pipe_busy;

  gsi_bell_pipe u_bell (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .den_i  (den_q),
    .item_i (pipe_in),
    .item_o (pipe_out),
    .busy_o (pipe_busy)
  );

  assign s_axis_tready_o = state_q == gsi_pkg::S_IDLE;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_st_q, out_int_q};

  assign bad_count = (n_q == '0) || n_q[0] || (32'(n_q) > 32'(MAX_INTERVALS));
  assign bad_dev   = sd_q[31] || (sd_q == '0);
  assign d_w       = {a_q[31], a_q} - {mu_q[31], mu_q};
  assign neg       = w_q[32];
  assign w_abs     = neg ? 33'(-w_q) : 33'(w_q);
  assign num_abs   = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
  assign an        = num_abs[ANW-1:0];

  assign chunk   = mul_b_q[{mul_cnt_q, 4'b0} +: 16];
  assign part    = 64'(mul_a_q) * 64'(chunk);
  assign mul_sum = mul_acc_q + (MPW'(part) << {mul_cnt_q, 4'b0});

  assign dtrial = {rem_q, dvd_q[VW-1]};
  assign dge    = dtrial >= {1'b0, divisor_q};

  assign lim = neg ? gsi_pkg::NEG_LIMIT : gsi_pkg::POS_LIMIT;
  assign sat = dvd_q > VW'(lim);
  assign mag = sat ? lim : dvd_q[31:0];

  always_comb begin
    pipe_in.valid = state_q == gsi_pkg::S_FEED;
    pipe_in.an    = an;
    pipe_in.tail  = {1'b0, an} >= {den_q, 4'b0};
    if ((idx_q == '0) || (idx_q == n_q)) begin
      pipe_in.wt = gsi_pkg::WT_ONE;
    end else if (idx_q[0]) begin
      pipe_in.wt = gsi_pkg::WT_FOUR;
    end else begin
      pipe_in.wt = gsi_pkg::WT_TWO;
    end
  end

  always_comb begin
    case (pipe_out.wt)
      gsi_pkg::WT_ONE:  inc = SUMW'(pipe_out.e);
      gsi_pkg::WT_TWO:  inc = SUMW'(pipe_out.e) << 1;
      gsi_pkg::WT_FOUR: inc = SUMW'(pipe_out.e) << 2;
      default:          inc = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gsi_pkg::S_IDLE:      if (in_xfer) state_d = gsi_pkg::S_SETUP;
      gsi_pkg::S_SETUP:     state_d = (bad_count || bad_dev) ? gsi_pkg::S_FINISH
                                                             : gsi_pkg::S_FEED;
      gsi_pkg::S_FEED:      if (idx_q == n_q) state_d = gsi_pkg::S_DRAIN;
      gsi_pkg::S_DRAIN:     if (!pipe_busy) state_d = gsi_pkg::S_MUL_AMP;
      gsi_pkg::S_MUL_AMP:   if (mul_cnt_q == 2'd2) state_d = gsi_pkg::S_MUL_SCALE;
      gsi_pkg::S_MUL_SCALE: if (mul_cnt_q == 2'd2) state_d = gsi_pkg::S_DIVIDE;
      gsi_pkg::S_DIVIDE:    if (div_cnt_q == VCW'(VW - 1)) state_d = gsi_pkg::S_PACK;
      gsi_pkg::S_PACK:      state_d = gsi_pkg::S_FINISH;
      gsi_pkg::S_FINISH:    if (out_free) state_d = gsi_pkg::S_IDLE;
      default:              state_d = gsi_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    w_d         = w_q;
    num_d       = num_q;
    den_d       = den_q;
    divisor_d   = divisor_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    mul_acc_d   = mul_acc_q;
    mul_cnt_d   = mul_cnt_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    div_cnt_d   = div_cnt_q;
    res_int_d   = res_int_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_int_d   = out_int_q;
    out_st_d    = out_st_q;

    if (pipe_out.valid) begin
      sum_d = sum_q + inc;
    end

    unique case (state_q)
      gsi_pkg::S_IDLE: begin
      end
      gsi_pkg::S_SETUP: begin
        w_d   = {b_q[31], b_q} - {a_q[31], a_q};
        num_d = d_w * $signed({1'b0, n_q});
        den_d = DW'(n_q) * DW'(sd_q[30:0]);
        idx_d = '0;
        sum_d = '0;
        if (bad_count) begin
          res_int_d = '0;
          res_st_d  = gsi_pkg::ST_BAD_COUNT;
        end else if (bad_dev) begin
          res_int_d = '0;
          res_st_d  = gsi_pkg::ST_BAD_DEV;
        end
      end
      gsi_pkg::S_FEED: begin
        num_d     = num_q + NW'(w_q);
        idx_d     = idx_q + 1'b1;
        divisor_d = RW'(den_q) + {RW'(den_q) << 1};
      end
      gsi_pkg::S_DRAIN: begin
        mul_a_d   = MW'(sum_q);
        mul_b_d   = MW'(gsi_pkg::INV_SQRT2PI_Q32);
        mul_acc_d = '0;
        mul_cnt_d = '0;
      end
      gsi_pkg::S_MUL_AMP: begin
        mul_acc_d = mul_sum;
        mul_cnt_d = mul_cnt_q + 1'b1;
        if (mul_cnt_q == 2'd2) begin
          mul_a_d   = MW'(w_abs);
          mul_b_d   = MW'(mul_sum[32 +: AMPW]);
          mul_acc_d = '0;
          mul_cnt_d = '0;
        end
      end
      gsi_pkg::S_MUL_SCALE: begin
        mul_acc_d = mul_sum;
        mul_cnt_d = mul_cnt_q + 1'b1;
        if (mul_cnt_q == 2'd2) begin
          dvd_d     = VW'(mul_sum >> SHR);
          rem_d     = '0;
          div_cnt_d = '0;
        end
      end
      gsi_pkg::S_DIVIDE: begin
        rem_d     = dge ? RW'(dtrial - {1'b0, divisor_q}) : dtrial[RW-1:0];
        dvd_d     = {dvd_q[VW-2:0], dge};
        div_cnt_d = div_cnt_q + 1'b1;
      end
      gsi_pkg::S_PACK: begin
        res_int_d = neg ? 32'(-mag) : mag;
        res_st_d  = sat ? gsi_pkg::ST_SAT : gsi_pkg::ST_OK;
      end
      gsi_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_int_d   = res_int_q;
          out_st_d    = res_st_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gsi_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_q  <= s_axis_tdata_i[31:0];
      b_q  <= s_axis_tdata_i[63:32];
      mu_q <= s_axis_tdata_i[95:64];
      sd_q <= s_axis_tdata_i[127:96];
      n_q  <= s_axis_tdata_i[138:128];
    end
    w_q       <= w_d;
    num_q     <= num_d;
    den_q     <= den_d;
    divisor_q <= divisor_d;
    idx_q     <= idx_d;
    sum_q     <= sum_d;
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    mul_acc_q <= mul_acc_d;
    mul_cnt_q <= mul_cnt_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    div_cnt_q <= div_cnt_d;
    res_int_q <= res_int_d;
    res_st_q  <= res_st_d;
    out_int_q <= out_int_d;
    out_st_q  <= out_st_d;
  end

  `GSI_ASSERT_IMP(a_setup_pipe_empty, state_q == gsi_pkg::S_SETUP, !pipe_busy, "pipe busy at job start")
  `GSI_ASSERT_IMP(a_pipe_out_in_job, pipe_out.valid, state_q == gsi_pkg::S_FEED || state_q == gsi_pkg::S_DRAIN, "density out of job")
  `GSI_ASSERT_IMP(a_div_rem_bound, state_q == gsi_pkg::S_DIVIDE, rem_q < divisor_q, "divider remainder out of range")
  `GSI_ASSERT_IMP(a_sat_value, out_valid_q && out_st_q == gsi_pkg::ST_SAT, out_int_q == gsi_pkg::POS_LIMIT || out_int_q == gsi_pkg::NEG_LIMIT, "saturated result not at a limit")
  `GSI_ASSERT(a_ready_only_idle, !s_axis_tready_o || !pipe_busy, "job accepted while pipe busy")

endmodule

`default_nettype wire

// ===== tb/sv/tb_gaussian_simpson_integrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_simpson_integrator
// Self-checking bench for the Gaussian Simpson integrator: jobs go in on the
// input stream, a bit-exact predictor computes each integral and status, and
// a monitor compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_gaussian_simpson_integrator;

  typedef struct packed {
    logic [10:0] count;
    logic [31:0] sd;
    logic [31:0] mu;
    logic [31:0] stop;
    logic [31:0] start;
  } job_t;

  typedef struct packed {
    gsi_pkg::status_e status;
    logic [31:0]      integral;
  } answer_t;

  logic         clk_i;
  logic         rst_ni;
  logic [143:0] s_axis_tdata_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [39:0]  m_axis_tdata_o;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;

  answer_t pending_answers[$];
  int      mismatches;
  bit      no_idle;
  int      hold_left;

  gaussian_simpson_integrator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // exp(-z^2/2) in q31 for z = num / den
  function automatic logic [63:0] density_q31(longint num, logic [63:0] den);
    logic [63:0] an, zq, t, s, term, g;
    longint acc;
    an = (num < 0) ? 64'(-num) : 64'(num);
    if (an >= den * 64'd16) return 64'd0;
    zq = (an << 16) / den;
    t = (zq * zq) >> 17;
    s = t << 8;
    term = 64'h8000_0000;
    acc = 64'sh8000_0000;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * s) >> 31) / 64'(k);
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > 64'sh8000_0000) acc = 64'sh8000_0000;
    g = 64'(acc);
    for (int k = 0; k < 7; k++) g = (g * g + (64'd1 << 30)) >> 31;
    return g;
  endfunction

  function automatic answer_t simpson_integral(job_t j);
    answer_t     r;
    longint      a, b, mu, sd, w, d, n, den, num;
    logic [63:0] sum, amp, wt, lim;
    logic [127:0] p, q, divisor;
    bit          neg;
    a = longint'($signed(j.start));
    b = longint'($signed(j.stop));
    mu = longint'($signed(j.mu));
    sd = longint'($signed(j.sd));
    n = longint'(j.count);
    r.integral = '0;
    r.status = gsi_pkg::ST_OK;
    if (n == 0 || n % 2 == 1 || n > 1024) begin
      r.status = gsi_pkg::ST_BAD_COUNT;
      return r;
    end
    if (sd <= 0) begin
      r.status = gsi_pkg::ST_BAD_DEV;
      return r;
    end
    w = b - a;
    d = a - mu;
    den = n * sd;
    sum = 0;
    for (longint i = 0; i <= n; i++) begin
      num = d * n + i * w;
      wt = (i == 0 || i == n) ? 64'd1 : ((i % 2 == 1) ? 64'd4 : 64'd2);
      sum = sum + wt * density_q31(num, 64'(den));
    end
    p = (128'(sum) * 128'(gsi_pkg::INV_SQRT2PI_Q32)) >> 32;
    amp = p[63:0];
    neg = w < 0;
    p = (128'(neg ? -w : w) * 128'(amp)) >> 15;
    divisor = 128'(3 * n * sd);
    q = p / divisor;
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    if (q > 128'(lim)) begin
      r.status = gsi_pkg::ST_SAT;
      q = 128'(lim);
    end
    r.integral = neg ? 32'(-q[63:0]) : q[31:0];
    return r;
  endfunction

  task automatic send_job(job_t j);
    @(negedge clk_i);
    if (!no_idle && $urandom_range(0, 99) < 32) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tdata_i = {5'b0, j};
    s_axis_tvalid_i = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_answers.push_back(simpson_integral(j));
  endtask

  function automatic job_t mk(int start, int stop, int mu, int sd, int count);
    job_t j;
    j.start = start;
    j.stop = stop;
    j.mu = mu;
    j.sd = sd;
    j.count = 11'(count);
    return j;
  endfunction

  function automatic job_t random_job();
    job_t j;
    int   pick;
    int   sd;
    pick = $urandom_range(0, 99);
    j = mk($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 2047));
    if (pick < 8) begin
      // broken count: zero, odd or past the bound
      case ($urandom_range(0, 2))
        0: j.count = 0;
        1: j.count = 11'($urandom_range(0, 1023) * 2 + 1);
        default: j.count = 11'($urandom_range(1025, 2047));
      endcase
    end else if (pick < 13) begin
      j.count = 11'($urandom_range(1, 32) * 2);
      j.sd = ($urandom_range(0, 3) == 0) ? 32'd0 : (32'h8000_0000 | $urandom);
    end else if (pick < 20) begin
      // full-width fields with a valid count
      j.count = 11'($urandom_range(1, 32) * 2);
    end else begin
      sd = $urandom_range(1 << 10, 1 << 20);
      j.sd = sd;
      j.mu = $urandom_range(0, 1 << 24) - (1 << 23);
      j.start = j.mu + $urandom_range(0, 8 * sd) - 6 * sd;
      j.stop = j.mu + $urandom_range(0, 8 * sd) - 2 * sd;
      if ($urandom_range(0, 59) == 0) j.count = 1024;
      else if ($urandom_range(0, 29) == 0) j.count = 11'($urandom_range(1, 512) * 2);
      else j.count = 11'($urandom_range(1, 32) * 2);
    end
    return j;
  endfunction

  task automatic test_directed();
    send_job(mk(0, 32'h0001_0000, 0, 32'h0001_0000, 0));
    send_job(mk(0, 32'h0001_0000, 0, 32'h0001_0000, 1));
    send_job(mk(0, 32'h0001_0000, 0, 32'h0001_0000, 2047));
    send_job(mk(0, 32'h0001_0000, 0, 32'h0001_0000, 1026));
    send_job(mk(0, 32'h0001_0000, 0, 0, 8));
    send_job(mk(0, 32'h0001_0000, 0, 32'hffff_0000, 8));
    send_job(mk(0, 32'h0001_0000, 0, 32'h8000_0000, 8));
    // bad count wins over bad deviation
    send_job(mk(0, 32'h0001_0000, 0, 0, 3));
    send_job(mk(32'hfffe_0000, 32'h0002_0000, 0, 32'h0001_0000, 2));
    send_job(mk(32'hfffe_0000, 32'h0002_0000, 0, 32'h0001_0000, 1024));
    send_job(mk(32'hfffd_0000, 32'h0003_0000, 0, 32'h0001_0000, 32));
    // reversed limits
    send_job(mk(32'h0003_0000, 32'hfffd_0000, 0, 32'h0001_0000, 32));
    // empty range
    send_job(mk(32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000, 16));
    // far tail
    send_job(mk(32'h0040_0000, 32'h0050_0000, 0, 32'h0001_0000, 8));
    // coarse grid on a narrow bell saturates both ways
    send_job(mk(32'hc000_0000, 32'h4000_0000, 0, 1, 2));
    send_job(mk(32'h4000_0000, 32'hc000_0000, 0, 1, 2));
    send_job(mk(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 2));
    send_job(mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1, 1024));
    send_job(mk(32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 64));
    send_job(mk(0, 32'h0000_4000, 32'h0000_2000, 32'h0000_0100, 20));
  endtask

  task automatic test_random(int items);
    for (int i = 0; i < items; i++) begin
      // long stretch with no idling on either side
      no_idle = (i >= items / 3 && i < items / 3 + 60);
      send_job(random_job());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_left = 900;
    for (int i = 0; i < 6; i++)
      send_job(mk(32'hffff_0000, 32'h0001_0000, 0, 32'h0000_8000, 2 * (i + 1)));
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 5; i++) send_job(random_job());
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    wait (pending_answers.size() == 0);
    for (int i = 0; i < 5; i++) send_job(random_job());
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready_i <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 32);
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", m_axis_tdata_o);
      end else begin
        want = pending_answers.pop_front();
        if (m_axis_tdata_o[31:0] !== want.integral ||
            m_axis_tdata_o[33:32] !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: integral exp %h got %h, status exp %0d got %0d",
                     want.integral, m_axis_tdata_o[31:0], want.status,
                     m_axis_tdata_o[33:32]);
        end
      end
    end
  end

  initial begin
    #60ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    mismatches = 0;
    no_idle = 1'b0;
    hold_left = 0;
    s_axis_tdata_i = '0;
    s_axis_tvalid_i = 1'b0;
    m_axis_tready_i = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random(500);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    wait (pending_answers.size() == 0);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== gaussian_simpson_integrator.f =====
+incdir+hw/rtl
hw/rtl/gsi_pkg.sv
hw/rtl/gsi_bell_pipe.sv
hw/rtl/gaussian_simpson_integrator.sv
tb/sv/tb_gaussian_simpson_integrator.sv
